>>> rtl/core/mpq_pkg.sv
// types and constants shared by the priority queue cells and top level
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int DATA_W = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;

    // what one cell shows to its neighbors
    typedef struct packed {
        logic  valid;
        logic  keep;
        data_t value;
    } cell_link_t;

endpackage

>>> rtl/core/mpq_cell.sv
// one storage cell of the sorted shift-register queue
`timescale 1ns / 1ps

module mpq_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               do_insert,
    input  logic               do_pop,
    input  mpq_pkg::data_t     key,
    input  mpq_pkg::cell_link_t left,
    input  mpq_pkg::cell_link_t right,
    output mpq_pkg::cell_link_t link
);

    logic           valid_reg;
    logic           valid_next;
    mpq_pkg::data_t value_reg;
    mpq_pkg::data_t value_next;
    logic           keep;

    // entry stays in place when it is not larger than the new key
    assign keep = valid_reg && (value_reg <= key);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (do_insert)
        begin
            valid_next = valid_reg | left.valid;
            if (!keep)
            begin
                value_next = left.keep ? key : left.value;
            end
        end
        else if (do_pop)
        begin
            valid_next = right.valid;
            value_next = right.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.keep  = keep;
    assign link.value = value_reg;

endmodule

>>> rtl/core/min_priority_queue_unit.sv
// min priority queue built from a row of sorted shift-register cells
//
//  channel   valid       stall       payload
//  request   req_valid   req_stall   opcode, value
//  response  rsp_valid   rsp_stall   out_value, status
//
// one request per cycle while req_stall is low: every cell compares against the new key in parallel
// and shifts one place, so the request completes in the cycle it is taken
// a pop or a dropped insert gives a registered response in the cycle after the request
// reset empties the queue by clearing the cell valid bits
// requests stall only while a response is held by a stalled response channel
`timescale 1ns / 1ps

module min_priority_queue_unit
#(
    parameter int CAPACITY = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic                      opcode,
    input  logic signed [31:0]        value,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic signed [31:0]        out_value,
    output logic [1:0]                status
);

    localparam int LAST = CAPACITY - 1;

    mpq_pkg::cell_link_t link [CAPACITY];
    mpq_pkg::cell_link_t left_in [CAPACITY];
    mpq_pkg::cell_link_t right_in [CAPACITY];

    logic           accept;
    logic           full;
    logic           empty;
    logic           do_insert;
    logic           do_pop;
    logic           respond;

    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    mpq_pkg::data_t out_value_reg;
    mpq_pkg::data_t out_value_next;
    logic [1:0]     status_reg;
    logic [1:0]     status_next;

    assign full  = link[LAST].valid;
    assign empty = !link[0].valid;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign do_insert = accept && (opcode == mpq_pkg::OP_INSERT) && !full;
    assign do_pop    = accept && (opcode == mpq_pkg::OP_POP) && !empty;
    assign respond   = accept && ((opcode == mpq_pkg::OP_POP) || full);

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign left_in[i] = '{valid: 1'b1, keep: 1'b1, value: '0};
            end
            else
            begin : g_body
                assign left_in[i] = link[i-1];
            end

            if (i == LAST)
            begin : g_tail
                assign right_in[i] = '{valid: 1'b0, keep: 1'b0, value: '0};
            end
            else
            begin : g_mid
                assign right_in[i] = link[i+1];
            end

            mpq_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .do_insert (do_insert),
                .do_pop    (do_pop),
                .key       (value),
                .left      (left_in[i]),
                .right     (right_in[i]),
                .link      (link[i])
            );
        end
    endgenerate

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        if (respond)
        begin
            rsp_valid_next = 1'b1;
            if (opcode == mpq_pkg::OP_INSERT)
            begin
                out_value_next = '0;
                status_next    = mpq_pkg::STATUS_FULL;
            end
            else if (empty)
            begin
                out_value_next = '0;
                status_next    = mpq_pkg::STATUS_EMPTY;
            end
            else
            begin
                out_value_next = link[0].value;
                status_next    = mpq_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;

    a_full_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue reports full and empty at once");

    a_pop_returns_value : assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> rsp_valid && (status == mpq_pkg::STATUS_OK))
        else $error("pop of a stored value did not return it");

    a_insert_fills_head : assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> link[0].valid)
        else $error("insert left the head cell empty");

    a_insert_silent : assert property (@(posedge clk) disable iff (!rst_n)
        do_insert && !req_stall && !rsp_stall |=> !rsp_valid)
        else $error("stored insert produced a response");

endmodule
